[hdl/ncgc_pkg.sv]
// Package for the nodal / cell-center grid converter.
// Holds sizing constants, operation and register codes, and the structs
// passed between the core and the address generator. No dependencies.
package ncgc_pkg;

  localparam int MAX_EXTENT   = 32;
  localparam int STORE_DEPTH  = 131072;
  localparam int SAMPLE_WIDTH = 32;

  // Grid points per axis in the store layout (nodes reach the extent).
  localparam int EXT = MAX_EXTENT + 1;

  localparam int COORD_W = 6;
  localparam int COMP_W  = 2;
  localparam int SIZE_W  = 6;
  localparam int EXT_W   = $clog2(MAX_EXTENT + 2);
  localparam int CMP_W   = (EXT_W > COORD_W) ? EXT_W : COORD_W;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int SPAN_W  = $clog2(3 * EXT * EXT * EXT);
  localparam int IDX_W   = ((SPAN_W > ADDR_W) ? SPAN_W : ADDR_W) + 1;

  // Sum of up to eight samples, wrapped at 64 bits like the arithmetic spec.
  localparam int SUM_W   = (SAMPLE_WIDTH + 3 > 64) ? 64 : SAMPLE_WIDTH + 3;
  localparam int WIDE_W  = (SUM_W > 33) ? SUM_W : 33;
  localparam int VAL_W   = 32;

  localparam int NBR_W   = 3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic MODE_TO_CENTER = 1'b0;
  localparam logic MODE_TO_NODE   = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd4;

  typedef struct packed {
    logic             to_node;
    logic             three;
    logic [CMP_W-1:0] sx;
    logic [CMP_W-1:0] sy;
    logic [CMP_W-1:0] sz;
  } grid_cfg_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } store_req_t;

endpackage

[hdl/ncgc_ram.sv]
// Single-port synchronous sample store with registered read data.
// Generic; no package dependency.
module ncgc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

[hdl/ncgc_addr_gen.sv]
// Neighbor coordinate and store address generator.
// Depends on ncgc_pkg for widths, the grid configuration and request structs.
module ncgc_addr_gen
  import ncgc_pkg::*;
(
  input  grid_cfg_t          cfg,
  input  logic               direct,
  input  logic [NBR_W-1:0]   nbr,
  input  logic [COORD_W-1:0] pos_x,
  input  logic [COORD_W-1:0] pos_y,
  input  logic [COORD_W-1:0] pos_z,
  input  logic [COMP_W-1:0]  comp,
  output store_req_t         req
);

  logic               ok;
  logic [COORD_W-1:0] cx, cy, cz;
  logic [IDX_W-1:0]   idx;

  // Corner nodes of a cell lie at +0/+1; cells around a node at -1/+0,
  // dropped where they fall off the border.
  always_comb begin
    ok = 1'b1;
    cx = pos_x;
    cy = pos_y;
    cz = pos_z;
    if (!direct) begin
      if (cfg.to_node == MODE_TO_CENTER) begin
        cx = pos_x + COORD_W'(nbr[0]);
        cy = pos_y + COORD_W'(nbr[1]);
        if (cfg.three) begin
          cz = pos_z + COORD_W'(nbr[2]);
        end
      end else begin
        if (!nbr[0]) begin
          if (pos_x == '0) ok = 1'b0;
          cx = pos_x - COORD_W'(1);
        end else if (CMP_W'(pos_x) >= cfg.sx) begin
          ok = 1'b0;
        end
        if (!nbr[1]) begin
          if (pos_y == '0) ok = 1'b0;
          cy = pos_y - COORD_W'(1);
        end else if (CMP_W'(pos_y) >= cfg.sy) begin
          ok = 1'b0;
        end
        if (cfg.three) begin
          if (!nbr[2]) begin
            if (pos_z == '0) ok = 1'b0;
            cz = pos_z - COORD_W'(1);
          end else if (CMP_W'(pos_z) >= cfg.sz) begin
            ok = 1'b0;
          end
        end
      end
    end
    idx = ((IDX_W'(comp) * IDX_W'(EXT) + IDX_W'(cz)) * IDX_W'(EXT) + IDX_W'(cy))
          * IDX_W'(EXT) + IDX_W'(cx);
    req.hit  = ok && (idx < IDX_W'(STORE_DEPTH));
    req.addr = idx[ADDR_W-1:0];
  end

endmodule

[hdl/nodal_center_grid_convert_core.sv]
// Nodal / cell-center grid converter top level; needs ncgc_pkg, ncgc_addr_gen, ncgc_ram.
// A read walks GATHER, one store read per neighbor (4 in 2-D, 8 in 3-D), then
// DRAIN and FINISH into the output register; a range error goes to FINISH directly.
// Items are taken only in IDLE; an in-range write passes through WRITE, a dropped
// one stays in IDLE. rst_n (synchronous, active low) clears control and config
// registers; the payload registers and the sample store are not cleared.
module nodal_center_grid_convert_core
  import ncgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Input item. tdata, low bit up: pos_x[5:0], pos_y[11:6], pos_z[17:12],
  // component[19:18], sample_in[51:20], zero fill [55:52].
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [55:0]          in_tdata,
  // tuser: operation[0].
  input  logic [0:0]           in_tuser,
  // Result item. tdata: read_value[31:0].
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,
  // tuser: range_error[0].
  output logic [0:0]           out_tuser,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRITE  = 3'd1;
  localparam logic [2:0] S_GATHER = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic signed [WIDE_W-1:0] Q_MAX = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] Q_MIN = WIDE_W'(-64'sd2147483648);

  // Configuration registers.
  logic              mode_r;
  logic [1:0]        num_dims_r;
  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;

  // Sequencer and item registers.
  logic [2:0]              state_r, state_nxt;
  logic [NBR_W-1:0]        nbr_r, nbr_nxt;
  logic                    hit_d_r, hit_d_nxt;
  logic                    err_r, err_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [COORD_W-1:0]      x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [COMP_W-1:0]       c_r, c_nxt;
  logic [SAMPLE_WIDTH-1:0] samp_r, samp_nxt;

  // Output register, which frees the input side while a result waits.
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_data_r, out_data_nxt;
  logic             out_err_r, out_err_nxt;

  grid_cfg_t  cfg;
  store_req_t req;
  logic       ram_en, ram_we;
  logic [SAMPLE_WIDTH-1:0]        rd_data;
  logic signed [SAMPLE_WIDTH-1:0] rd_s;

  logic               in_fire;
  logic               in_op;
  logic [COORD_W-1:0] in_x, in_y, in_z;
  logic [COMP_W-1:0]  in_c;
  logic signed [31:0] in_sample;

  logic signed [WIDE_W-1:0] wide_sum, quot;
  logic [VAL_W-1:0]         result;
  logic                     last_nbr;

  // Sizes of zero act as one, sizes beyond the extent are clamped.
  function automatic logic [CMP_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [CMP_W-1:0] w;
    w = CMP_W'(s);
    if (s == '0) begin
      return CMP_W'(1);
    end else if (w > CMP_W'(MAX_EXTENT)) begin
      return CMP_W'(MAX_EXTENT);
    end
    return w;
  endfunction

  // Coordinate check; a nodal grid has one more point per axis than cells.
  function automatic logic grid_ok(input logic nodal, input grid_cfg_t g,
                                   input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y,
                                   input logic [COORD_W-1:0] z,
                                   input logic [COMP_W-1:0] c);
    logic [CMP_W-1:0] add;
    logic             ok;
    add = CMP_W'(nodal);
    ok  = 1'b1;
    if (c >= (g.three ? COMP_W'(3) : COMP_W'(2))) ok = 1'b0;
    if (CMP_W'(x) >= g.sx + add) ok = 1'b0;
    if (CMP_W'(y) >= g.sy + add) ok = 1'b0;
    if (g.three) begin
      if (CMP_W'(z) >= g.sz + add) ok = 1'b0;
    end else if (z != '0) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  assign cfg.to_node = mode_r;
  assign cfg.three   = (num_dims_r == 2'd3);
  assign cfg.sx      = eff_size(size_x_r);
  assign cfg.sy      = eff_size(size_y_r);
  assign cfg.sz      = eff_size(size_z_r);

  assign in_op     = in_tuser[0];
  assign in_x      = in_tdata[5:0];
  assign in_y      = in_tdata[11:6];
  assign in_z      = in_tdata[17:12];
  assign in_c      = in_tdata[19:18];
  assign in_sample = in_tdata[51:20];

  // The block takes one item at a time; the output register holds a
  // finished result so a new transfer can be taken while it waits.
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  // Address generation for the current neighbor, or the write target.
  ncgc_addr_gen u_addr_gen (
    .cfg    (cfg),
    .direct (state_r == S_WRITE),
    .nbr    (nbr_r),
    .pos_x  (x_r),
    .pos_y  (y_r),
    .pos_z  (z_r),
    .comp   (c_r),
    .req    (req)
  );

  assign ram_we = (state_r == S_WRITE) && req.hit;
  assign ram_en = ram_we || ((state_r == S_GATHER) && req.hit);

  ncgc_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (SAMPLE_WIDTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (req.addr),
    .wdata (samp_r),
    .rdata (rd_data)
  );

  assign rd_s = rd_data;

  // The division by 4 or 8 is a floor arithmetic shift of the exact sum.
  always_comb begin
    wide_sum = WIDE_W'(sum_r);
    quot     = cfg.three ? (wide_sum >>> 3) : (wide_sum >>> 2);
    if (quot > Q_MAX) begin
      result = VAL_W'(Q_MAX);
    end else if (quot < Q_MIN) begin
      result = VAL_W'(Q_MIN);
    end else begin
      result = quot[VAL_W-1:0];
    end
  end

  assign last_nbr = cfg.three ? (nbr_r == NBR_W'(7)) : (nbr_r == NBR_W'(3));

  always_comb begin
    state_nxt     = state_r;
    nbr_nxt       = nbr_r;
    hit_d_nxt     = 1'b0;
    err_nxt       = err_r;
    sum_nxt       = sum_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    c_nxt         = c_r;
    samp_nxt      = samp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_err_nxt   = out_err_r;

    // Read data of the neighbor issued in the previous cycle lands now.
    if (((state_r == S_GATHER) || (state_r == S_DRAIN)) && hit_d_r) begin
      sum_nxt = sum_r + SUM_W'(rd_s);
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          x_nxt    = in_x;
          y_nxt    = in_y;
          z_nxt    = in_z;
          c_nxt    = in_c;
          samp_nxt = SAMPLE_WIDTH'(in_sample);
          sum_nxt  = '0;
          nbr_nxt  = '0;
          if (in_op == OP_WRITE) begin
            // The stored grid is nodal when reads give cell centers.
            if (grid_ok(mode_r == MODE_TO_CENTER, cfg, in_x, in_y, in_z, in_c)) begin
              state_nxt = S_WRITE;
            end
          end else if (!grid_ok(mode_r == MODE_TO_NODE, cfg, in_x, in_y, in_z, in_c)) begin
            err_nxt   = 1'b1;
            state_nxt = S_FINISH;
          end else begin
            err_nxt   = 1'b0;
            state_nxt = S_GATHER;
          end
        end
      end
      S_WRITE: begin
        state_nxt = S_IDLE;
      end
      S_GATHER: begin
        hit_d_nxt = req.hit;
        nbr_nxt   = nbr_r + NBR_W'(1);
        if (last_nbr) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = err_r ? '0 : result;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nbr_r       <= '0;
      hit_d_r     <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_TO_CENTER;
      num_dims_r  <= 2'd2;
      size_x_r    <= SIZE_W'(32);
      size_y_r    <= SIZE_W'(32);
      size_z_r    <= SIZE_W'(32);
    end else begin
      state_r     <= state_nxt;
      nbr_r       <= nbr_nxt;
      hit_d_r     <= hit_d_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:     mode_r     <= cfg_wdata[0];
          REG_NUM_DIMS: num_dims_r <= cfg_wdata[1:0];
          REG_SIZE_X:   size_x_r   <= cfg_wdata;
          REG_SIZE_Y:   size_y_r   <= cfg_wdata;
          REG_SIZE_Z:   size_z_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    c_r        <= c_nxt;
    samp_r     <= samp_nxt;
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
  end

endmodule

[dv/ncgc_checker.sv]
// Scoreboard for the nodal / cell-center grid converter: watches the input,
// result and configuration ports, predicts every read and compares it.
// Depends on ncgc_pkg only.
`timescale 1ns / 100ps

module ncgc_checker
  import ncgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [55:0]          in_tdata,
  input  logic [0:0]           in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [31:0]          out_tdata,
  input  logic [0:0]           out_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  output int                   fail_count,
  output int                   outstanding
);

  typedef struct packed {
    logic [31:0] value;
    logic        err;
  } grid_read_t;

  // Shadow copy of the sample store and of the configuration registers.
  int         grid_samples [STORE_DEPTH];
  grid_read_t reads_due [$];
  logic              to_node_r;
  logic [1:0]        dims_r;
  logic [SIZE_W-1:0] sx_r;
  logic [SIZE_W-1:0] sy_r;
  logic [SIZE_W-1:0] sz_r;

  function automatic int fit_size(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_EXTENT) return MAX_EXTENT;
    return int'(s);
  endfunction

  function automatic int slot_of(int c, int z, int y, int x);
    return ((c * EXT + z) * EXT + y) * EXT + x;
  endfunction

  // Nodal grids hold one more point per axis than the cell grid.
  function automatic bit inside_grid(bit nodal, int c, int z, int y, int x);
    int pad;
    bit three;
    pad = nodal ? 1 : 0;
    three = (dims_r == 2'd3);
    if (c >= (three ? 3 : 2)) return 1'b0;
    if (x >= fit_size(sx_r) + pad || y >= fit_size(sy_r) + pad) return 1'b0;
    if (three) return z < fit_size(sz_r) + pad;
    return z == 0;
  endfunction

  function automatic grid_read_t convert_read(int c, int z, int y, int x);
    grid_read_t r;
    longint acc;
    bit three;
    int span, dz, dy, dx, cz, cy, cx;
    three = (dims_r == 2'd3);
    span = three ? 2 : 1;
    acc = 0;
    r.value = '0;
    r.err = 1'b0;
    if (!inside_grid(to_node_r, c, z, y, x)) begin
      r.err = 1'b1;
      return r;
    end
    for (dz = 0; dz < span; dz++)
      for (dy = 0; dy < 2; dy++)
        for (dx = 0; dx < 2; dx++) begin
          if (to_node_r == MODE_TO_CENTER) begin
            acc += longint'(grid_samples[slot_of(c, z + dz, y + dy, x + dx)]);
          end else begin
            // Cells around a node; those past the border count as zero.
            cz = three ? z - 1 + dz : z;
            cy = y - 1 + dy;
            cx = x - 1 + dx;
            if ((!three || (cz >= 0 && cz < fit_size(sz_r))) &&
                cy >= 0 && cy < fit_size(sy_r) && cx >= 0 && cx < fit_size(sx_r))
              acc += longint'(grid_samples[slot_of(c, cz, cy, cx)]);
          end
        end
    acc = acc >>> (three ? 3 : 2);
    if (acc > 64'sd2147483647) r.value = 32'h7fff_ffff;
    else if (acc < -64'sd2147483648) r.value = 32'h8000_0000;
    else r.value = acc[31:0];
    return r;
  endfunction

  task automatic report(string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    grid_read_t seen, want;
    int x, y, z, c;
    if (!rst_n) begin
      to_node_r = MODE_TO_CENTER;
      dims_r = 2'd2;
      sx_r = SIZE_W'(MAX_EXTENT);
      sy_r = SIZE_W'(MAX_EXTENT);
      sz_r = SIZE_W'(MAX_EXTENT);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:     to_node_r = cfg_wdata[0];
          REG_NUM_DIMS: dims_r = cfg_wdata[1:0];
          REG_SIZE_X:   sx_r = cfg_wdata;
          REG_SIZE_Y:   sy_r = cfg_wdata;
          REG_SIZE_Z:   sz_r = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        x = int'(in_tdata[5:0]);
        y = int'(in_tdata[11:6]);
        z = int'(in_tdata[17:12]);
        c = int'(in_tdata[19:18]);
        if (in_tuser[0] == OP_WRITE) begin
          if (inside_grid(!to_node_r, c, z, y, x))
            grid_samples[slot_of(c, z, y, x)] = int'(in_tdata[51:20]);
        end else begin
          reads_due.push_back(convert_read(c, z, y, x));
        end
      end
      if (out_tvalid && out_tready) begin
        seen.value = out_tdata;
        seen.err = out_tuser[0];
        if (reads_due.size() == 0) begin
          report($sformatf("result with no read pending: expected none, actual %h/%b",
                           seen.value, seen.err));
        end else begin
          want = reads_due.pop_front();
          if (seen.value !== want.value)
            report($sformatf("read_value expected %h actual %h", want.value, seen.value));
          if (seen.err !== want.err)
            report($sformatf("range_error expected %b actual %b", want.err, seen.err));
        end
      end
    end
    outstanding = reads_due.size();
  end

endmodule

[dv/testbench.sv]
// Top of the grid converter testbench: clock, reset, stimulus and verdict.
// Depends on ncgc_pkg, the nodal_center_grid_convert_core RTL and ncgc_checker.
`timescale 1ns / 100ps

module testbench;
  import ncgc_pkg::*;

  // A phase is one register setting followed by a burst of random traffic.
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 110;
  // The quietest phase: neither side idles there.
  localparam int CALM_PHASE  = 3;
  // Cycles to wait after the last result.
  localparam int SETTLE      = 12;
  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;

  typedef enum {FILL_MIXED, FILL_MAX, FILL_MIN} fill_kind_t;

  typedef struct {
    int c;
    int z;
    int y;
    int x;
  } grid_pt_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [55:0]          in_tdata = '0;
  logic [0:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic [0:0]           out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_wdata = '0;
  int                   fail_count;
  int                   outstanding;

  // The stimulus keeps its own view of the grid shape so that it can aim
  // coordinates, and a map of every store entry that holds a written sample.
  // A read is only issued once every entry it gathers has been written.
  bit         written [STORE_DEPTH];
  bit         cur_to_node = MODE_TO_CENTER;
  bit         cur_three = 1'b0;
  int         ex = MAX_EXTENT;
  int         ey = MAX_EXTENT;
  int         ez = MAX_EXTENT;
  int         base_x, base_y, base_z;
  int         phase_items;
  int         quiet;
  bit         calm = 1'b0;
  fill_kind_t fill_kind = FILL_MIXED;

  nodal_center_grid_convert_core uut (.*);

  ncgc_checker scoreboard (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The result side stalls at random, with odds of about 17 in a hundred, except in the calm phase.
  always @(posedge clk) out_tready <= calm || ($urandom_range(99) >= 17);

  // Hang detection. Sampled on the falling edge, where the handshake signals
  // show what the next rising edge will transfer.
  always @(negedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("%0t: watchdog expired, no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int fit_size(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_EXTENT) return MAX_EXTENT;
    return int'(s);
  endfunction

  function automatic int slot_of(grid_pt_t p);
    return ((p.c * EXT + p.z) * EXT + p.y) * EXT + p.x;
  endfunction

  // True when the point lies in a nodal (or, with nodal clear, cell) grid
  // of the current shape.
  function automatic bit on_grid(bit nodal, grid_pt_t p);
    int pad;
    pad = nodal ? 1 : 0;
    if (p.c >= (cur_three ? 3 : 2)) return 1'b0;
    if (p.x >= ex + pad || p.y >= ey + pad) return 1'b0;
    return cur_three ? (p.z < ez + pad) : (p.z == 0);
  endfunction

  function automatic logic [31:0] pick_sample();
    case (fill_kind)
      FILL_MAX: return 32'h7fff_ffff;
      FILL_MIN: return 32'h8000_0000;
      default: begin
        case ($urandom_range(7))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'($urandom_range(15)) - 32'd8;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Coordinates cluster around a per-phase window so that samples written
  // earlier are reused; the rest hit the edges or spread over the axis.
  function automatic int pick_pos(int lim, int base);
    case ($urandom_range(9))
      0, 1: return $urandom_range(lim);
      2: return 0;
      3: return lim;
      default: return (base + $urandom_range(2) > lim) ? lim : base + $urandom_range(2);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(3) != 0) return SIZE_W'($urandom_range(1, 5));
    return SIZE_W'($urandom_range(63));
  endfunction

  // One input transfer. The sender idles at random before it offers the
  // item, then holds it until the block takes it. in_tready is sampled on the
  // falling edge, so the decision never races the block's own update.
  task automatic send_item(logic op, grid_pt_t p, logic [31:0] smp);
    logic taken;
    if (!calm) begin
      while ($urandom_range(99) < 17) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0, smp, 2'(p.c), 6'(p.z), 6'(p.y), 6'(p.x)};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    phase_items++;
  endtask

  // A write; the map only learns about it when it lands inside the stored
  // grid, since the block ignores anything else.
  task automatic store_sample(grid_pt_t p, logic [31:0] v);
    if (on_grid(!cur_to_node, p)) written[slot_of(p)] = 1'b1;
    send_item(OP_WRITE, p, v);
  endtask

  // A read, preceded by writes for every gathered entry that is still blank.
  // Corner nodes of a cell in the nodal-to-center mode; in the other mode the
  // in-range cells that touch the node.
  task automatic query_point(grid_pt_t p);
    grid_pt_t gather [$];
    grid_pt_t q;
    int span, dz, dy, dx;
    span = cur_three ? 2 : 1;
    if (on_grid(cur_to_node, p)) begin
      for (dz = 0; dz < span; dz++)
        for (dy = 0; dy < 2; dy++)
          for (dx = 0; dx < 2; dx++) begin
            q.c = p.c;
            if (cur_to_node == MODE_TO_NODE) begin
              q.z = cur_three ? p.z - 1 + dz : p.z;
              q.y = p.y - 1 + dy;
              q.x = p.x - 1 + dx;
              if (q.z >= 0 && q.z < ez && q.y >= 0 && q.y < ey && q.x >= 0 && q.x < ex)
                gather.push_back(q);
            end else begin
              q.z = p.z + dz;
              q.y = p.y + dy;
              q.x = p.x + dx;
              gather.push_back(q);
            end
          end
      foreach (gather[i])
        if (!written[slot_of(gather[i])]) store_sample(gather[i], pick_sample());
    end
    send_item(OP_READ, p, $urandom);
  endtask

  // Waits until the block is idle: no result pending and enough cycles for a
  // write still in flight to finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Register setting of one phase. The first phases pin the extremes: full
  // 32-cell grids both ways, a single-cell grid, and sizes of 0 and 63 that
  // the block clamps to 1 and 32. Bits above the used ones carry noise.
  task automatic configure(int phase);
    logic [SIZE_W-1:0] mode_w, dims_w, sx_w, sy_w, sz_w;
    mode_w = SIZE_W'($urandom);
    dims_w = SIZE_W'($urandom);
    dims_w[1:0] = $urandom_range(1) ? 2'd3 : 2'($urandom_range(2));
    sx_w = pick_size();
    sy_w = pick_size();
    sz_w = pick_size();
    case (phase)
      1: begin
        mode_w[0] = MODE_TO_CENTER;
        dims_w[1:0] = 2'd3;
        sx_w = SIZE_W'(MAX_EXTENT);
        sy_w = SIZE_W'(MAX_EXTENT);
        sz_w = SIZE_W'(MAX_EXTENT);
      end
      2: begin
        mode_w[0] = MODE_TO_NODE;
        dims_w[1:0] = 2'd3;
        sx_w = SIZE_W'(MAX_EXTENT);
        sy_w = SIZE_W'(MAX_EXTENT);
        sz_w = SIZE_W'(MAX_EXTENT);
      end
      3: begin
        mode_w[0] = MODE_TO_NODE;
        dims_w[1:0] = 2'd0;
        sx_w = SIZE_W'(1);
        sy_w = SIZE_W'(1);
        sz_w = SIZE_W'(1);
      end
      4: begin
        mode_w[0] = MODE_TO_CENTER;
        dims_w[1:0] = 2'd3;
        sx_w = SIZE_W'(0);
        sy_w = SIZE_W'(63);
        sz_w = SIZE_W'(1);
      end
      5: begin
        mode_w[0] = MODE_TO_NODE;
        dims_w[1:0] = 2'd3;
        sx_w = SIZE_W'(63);
        sy_w = SIZE_W'(0);
        sz_w = SIZE_W'(2);
      end
      6: begin
        mode_w[0] = MODE_TO_CENTER;
        dims_w[1:0] = 2'd1;
        sx_w = SIZE_W'(1);
        sy_w = SIZE_W'(MAX_EXTENT);
        sz_w = SIZE_W'(5);
      end
      default: ;
    endcase
    write_reg(REG_MODE, mode_w);
    write_reg(REG_NUM_DIMS, dims_w);
    write_reg(REG_SIZE_X, sx_w);
    write_reg(REG_SIZE_Y, sy_w);
    write_reg(REG_SIZE_Z, sz_w);
    // Now and then an index past the last register, which must be ignored.
    if ($urandom_range(3) == 0)
      write_reg(REG_SIZE_Z + CFG_IDX_W'($urandom_range(1, 3)), SIZE_W'($urandom));
    cfg_we <= 1'b0;
    cur_to_node = mode_w[0];
    cur_three = (dims_w[1:0] == 2'd3);
    ex = fit_size(sx_w);
    ey = fit_size(sy_w);
    ez = fit_size(sz_w);
    base_x = $urandom_range(ex);
    base_y = $urandom_range(ey);
    base_z = cur_three ? $urandom_range(ez) : 0;
  endtask

  // One random step: mostly reads and writes aimed inside the grid, with a
  // share of coordinates and components that may fall anywhere.
  task automatic random_step();
    grid_pt_t p;
    int roll, pad;
    bit wild;
    roll = $urandom_range(99);
    wild = (roll >= 80);
    // Reads address the output grid, writes the stored one.
    pad = ((roll < 50 || (roll >= 80 && roll < 90)) == cur_to_node) ? 0 : -1;
    p.c = $urandom_range(cur_three ? 2 : 1);
    p.x = pick_pos(ex + pad, base_x);
    p.y = pick_pos(ey + pad, base_y);
    p.z = cur_three ? pick_pos(ez + pad, base_z) : 0;
    if (wild) begin
      if ($urandom_range(1)) p.c = $urandom_range(3);
      if ($urandom_range(1)) p.x = $urandom_range(63);
      if ($urandom_range(1)) p.y = $urandom_range(63);
      if ($urandom_range(1)) p.z = $urandom_range(63);
    end
    if (roll < 50 || (roll >= 80 && roll < 90)) query_point(p);
    else store_sample(p, pick_sample());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset setting: 2-D, nodes stored, 32 cells.
    // A top-corner cell whose nodes all hold the largest sample, and one at
    // the origin whose nodes all hold the most negative one.
    fill_kind = FILL_MAX;
    query_point('{1, 0, 31, 31});
    fill_kind = FILL_MIN;
    query_point('{0, 0, 0, 0});
    fill_kind = FILL_MIXED;
    // Reads outside the grid: x at the cell count, z set in 2-D, a third
    // component in 2-D, component 3, and every coordinate bit high.
    query_point('{0, 0, 0, MAX_EXTENT});
    query_point('{0, 1, 0, 0});
    query_point('{2, 0, 3, 3});
    query_point('{3, 0, 0, 0});
    query_point('{3, 63, 63, 63});
    // Writes outside the grid are dropped without a result.
    store_sample('{0, 0, 0, 40}, 32'h1234_5678);
    store_sample('{1, 0, 63, 0}, 32'hdead_beef);
    // An odd negative sum checks that the division rounds toward minus
    // infinity.
    store_sample('{0, 0, 0, 0}, 32'h0000_0001);
    query_point('{0, 0, 0, 0});
    // The outermost node, then the cell that uses it.
    store_sample('{0, 0, MAX_EXTENT, MAX_EXTENT}, $urandom);
    query_point('{0, 0, MAX_EXTENT - 1, MAX_EXTENT - 1});

    for (int phase = 1; phase <= PHASES; phase++) begin
      settle();
      configure(phase);
      calm = (phase == CALM_PHASE);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) random_step();
    end
    calm = 1'b0;
    settle();

    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ncgc_pkg.sv
hdl/ncgc_ram.sv
hdl/ncgc_addr_gen.sv
hdl/nodal_center_grid_convert_core.sv
dv/ncgc_checker.sv
dv/testbench.sv
